/* rtl/core/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// lfu_pkg: shared constants and helpers for the usage table
// Field widths, count limits, stream packing and count arithmetic.
// ----------------------------------------------------------------------------
package lfu_pkg;

  // field widths
  localparam int SYM_W = 16;
  localparam int CNT_W = 14;
  localparam int POS_W = 5;
  localparam int CAP_W = 6;
  localparam int ENTRY_W = SYM_W + CNT_W;

  // stream widths (whole bytes)
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 40;

  // output tdata bit positions
  localparam int M_HIT_LSB = 0;
  localparam int M_POS_LSB = 1;
  localparam int M_CNT_LSB = 6;
  localparam int M_EV_LSB = 20;
  localparam int M_EVSYM_LSB = 21;

  // table defaults and limits
  localparam int DEPTH_DEFAULT = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd10;
  localparam logic [CNT_W-1:0] COUNT_MAX = 14'd9999;
  localparam logic [CNT_W-1:0] COUNT_ABOVE_MAX = 14'd10000;

  // hit update: increment, saturating at the maximum count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    r = (cnt < COUNT_MAX) ? cnt + CNT_W'(1) : COUNT_MAX;
    return r;
  endfunction

  // insert count: zero becomes one, large values clip to the maximum
  function automatic logic [CNT_W-1:0] clamp_init(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] r;
    if (cnt == '0) begin
      r = CNT_W'(1);
    end else if (cnt > COUNT_MAX) begin
      r = COUNT_MAX;
    end else begin
      r = cnt;
    end
    return r;
  endfunction

endpackage

/* rtl/core/lfu_entry_ram.sv */
// ----------------------------------------------------------------------------
// lfu_entry_ram: entry storage for the usage table
// One write port and one read port, read data registered.
// Each word holds a symbol id in the upper bits and its use count below.
// ----------------------------------------------------------------------------
module lfu_entry_ram #(
  parameter int DEPTH = lfu_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic [lfu_pkg::ENTRY_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic [lfu_pkg::ENTRY_W-1:0] rd_data
);
  import lfu_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lfu_usage_table.sv */
// ----------------------------------------------------------------------------
// lfu_usage_table: frequency-ranked symbol table with use counts
// A hit bumps the stored count (saturating); a miss appends the symbol,
// first evicting the earliest least-used entry when the table is full.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | symbol_id, initial_count
//  m_*      | out | m_tvalid/m_tready  | hit, position, new_count, evicted,
//           |     |                    | evicted_symbol
//  cfg_*    | in  | cfg_wen            | capacity
//
//  One item at a time. A hit scans the occupied entries once; an insert
//  scans them and then appends the symbol; an eviction adds a shift pass
//  that moves every entry behind the victim down by one place, with no
//  moves when the victim is the last entry. Both passes are paced by the
//  single read port of the entry RAM, one entry per cycle.
//  Reset (rst, synchronous) empties the table and sets capacity to 10; the
//  RAM itself is not cleared, entries beyond the occupancy are never read.
//  A new item is taken once the previous result sits in the output register;
//  a stalled output only holds the block once the next result is ready.
//
module lfu_usage_table #(
  parameter int DEPTH = lfu_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // symbol_id [15:0], initial_count [29:16], zero [31:30]
  input  logic [lfu_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // hit [0], position [5:1], new_count [19:6], evicted [20],
  // evicted_symbol [36:21], zero [39:37]
  output logic [lfu_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  input  logic                          cfg_wen,
  input  logic [lfu_pkg::CAP_W-1:0]     cfg_wdata
);
  import lfu_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0]         state;
  logic [CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]   occ;

  // current item
  logic [SYM_W-1:0]   sym;
  logic [CNT_W-1:0]   init_cnt;

  // read sequencing
  logic [OCC_W-1:0]   rd_cnt;
  logic               rd_pend;
  logic [IDX_W-1:0]   rd_tag;
  logic               rd_issue;

  // scan results
  logic               found;
  logic [IDX_W-1:0]   match_idx;
  logic [CNT_W-1:0]   match_cnt;
  logic [CNT_W-1:0]   min_cnt;
  logic [IDX_W-1:0]   min_idx;
  logic [SYM_W-1:0]   min_sym;

  // result under construction
  logic               res_hit;
  logic [POS_W-1:0]   res_pos;
  logic [CNT_W-1:0]   res_cnt;
  logic               res_ev;
  logic [SYM_W-1:0]   res_ev_sym;

  // RAM ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [ENTRY_W-1:0] rd_data;
  logic [SYM_W-1:0]   rd_sym;
  logic [CNT_W-1:0]   rd_uses;

  logic               scan_done;
  logic               shift_done;
  logic               table_full;
  logic [CMP_W-1:0]   occ_x;
  logic [CMP_W-1:0]   cap_x;
  logic [CNT_W-1:0]   hit_cnt;
  logic [CNT_W-1:0]   ins_cnt;

  lfu_entry_ram #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_issue),
    .rd_addr (rd_cnt[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign rd_sym  = rd_data[ENTRY_W-1:CNT_W];
  assign rd_uses = rd_data[CNT_W-1:0];

  // one read per cycle while entries remain in the current pass
  assign rd_issue   = ((state == ST_SCAN) || (state == ST_SHIFT)) && (rd_cnt < occ);
  assign scan_done  = (state == ST_SCAN) && !rd_issue && !rd_pend;
  assign shift_done = (state == ST_SHIFT) && !rd_issue && !rd_pend;

  // full when the table is not empty and occupancy reaches capacity or the RAM depth
  assign occ_x      = CMP_W'(occ);
  assign cap_x      = CMP_W'(capacity);
  assign table_full = (occ != '0) && ((occ_x >= cap_x) || (occ == OCC_FULL));

  assign hit_cnt = sat_inc(match_cnt);
  assign ins_cnt = clamp_init(init_cnt);

  // RAM write select: hit update, shift move, append
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = match_idx;
    wr_data = {sym, hit_cnt};
    if (scan_done && found) begin
      wr_en = 1'b1;
    end else if ((state == ST_SHIFT) && rd_pend) begin
      wr_en   = 1'b1;
      wr_addr = IDX_W'(rd_tag - IDX_W'(1));
      wr_data = rd_data;
    end else if (state == ST_APPEND) begin
      wr_en   = 1'b1;
      wr_addr = occ[IDX_W-1:0];
      wr_data = {sym, ins_cnt};
    end
  end

  assign s_tready = (state == ST_IDLE);

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // read tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
    end
    rd_tag <= rd_cnt[IDX_W-1:0];
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ      <= '0;
      found    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            sym        <= s_tdata[SYM_W-1:0];
            init_cnt   <= s_tdata[SYM_W+CNT_W-1:SYM_W];
            rd_cnt     <= '0;
            found      <= 1'b0;
            min_cnt    <= COUNT_ABOVE_MAX;
            min_idx    <= '0;
            min_sym    <= '0;
            res_ev     <= 1'b0;
            res_ev_sym <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_issue) begin
            rd_cnt <= rd_cnt + OCC_W'(1);
          end
          // compare returning entry: first match, first strict minimum
          if (rd_pend) begin
            if (!found && (rd_sym == sym)) begin
              found     <= 1'b1;
              match_idx <= rd_tag;
              match_cnt <= rd_uses;
            end
            if (rd_uses < min_cnt) begin
              min_cnt <= rd_uses;
              min_idx <= rd_tag;
              min_sym <= rd_sym;
            end
          end
          if (scan_done) begin
            if (found) begin
              res_hit <= 1'b1;
              res_pos <= POS_W'(match_idx);
              res_cnt <= hit_cnt;
              state   <= ST_DONE;
            end else if (table_full) begin
              res_ev     <= 1'b1;
              res_ev_sym <= min_sym;
              rd_cnt     <= OCC_W'(min_idx) + OCC_W'(1);
              state      <= ST_SHIFT;
            end else begin
              state <= ST_APPEND;
            end
          end
        end
        ST_SHIFT: begin
          if (rd_issue) begin
            rd_cnt <= rd_cnt + OCC_W'(1);
          end
          if (shift_done) begin
            occ   <= occ - OCC_W'(1);
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          res_hit <= 1'b0;
          res_pos <= POS_W'(occ);
          res_cnt <= ins_cnt;
          occ     <= occ + OCC_W'(1);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          // hand result to the output register once it is free
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output valid: set on hand-over, cleared after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!m_tvalid || m_tready)) begin
      m_tdata <= {(M_DATA_W - M_EVSYM_LSB - SYM_W)'(0), res_ev_sym, res_ev,
                  res_cnt, res_pos, res_hit};
    end
  end

endmodule

/* rtl/core/lfu_usage_chk.sv */
// ----------------------------------------------------------------------------
// lfu_usage_chk: port-level checks for the usage table
// Watches the stream ports and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module lfu_usage_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [lfu_pkg::M_DATA_W-1:0] m_tdata,
  input logic                         m_tvalid,
  input logic                         m_tready
);
  import lfu_pkg::*;

  logic [CNT_W-1:0] chk_cnt;
  logic             chk_hit;
  logic             chk_ev;
  logic [SYM_W-1:0] chk_ev_sym;

  assign chk_hit    = m_tdata[M_HIT_LSB];
  assign chk_cnt    = m_tdata[M_CNT_LSB+CNT_W-1:M_CNT_LSB];
  assign chk_ev     = m_tdata[M_EV_LSB];
  assign chk_ev_sym = m_tdata[M_EVSYM_LSB+SYM_W-1:M_EVSYM_LSB];

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item in flight: no transfer directly after an accepted one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // reported count stays in range
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (chk_cnt != '0) && (chk_cnt <= COUNT_MAX))
    else $error("count out of range");

  // a hit never evicts, and a result without eviction reports a zero symbol
  a_hit_no_ev: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(chk_hit && chk_ev) && (chk_ev || (chk_ev_sym == '0)))
    else $error("inconsistent eviction fields");

endmodule

bind lfu_usage_table lfu_usage_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tdata  (m_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready)
);
